// File: hdl/tcot_pkg.sv
// ----------------------------------------------------------------------------
// tcot_pkg: shared types and constants of the timed color override table
// Field widths, request and result structs, table entry layout, the lane
// format of the shared compare unit and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tcot_pkg;

    // Field widths
    localparam int TIME_W    = 63;
    localparam int CH_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Default number of table entries
    localparam int TABLE_DEPTH_DEF = 128;

    // Add checks: truncated (diff / 1000) <= 10000 is diff < 10001 * 1000
    localparam int US_PER_MS     = 1000;
    localparam int MAX_AHEAD_MS  = 10000;
    localparam int MAX_LENGTH_MS = 10000;
    localparam logic [TIME_W:0] AHEAD_LIMIT_US  = 64'((MAX_AHEAD_MS + 1) * US_PER_MS);
    localparam logic [TIME_W:0] LENGTH_LIMIT_US = 64'((MAX_LENGTH_MS + 1) * US_PER_MS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_RED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_GREEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_BLUE   = 2'd3;

    // Compare unit lanes
    localparam int NUM_LANES = 3;
    localparam int LANE_0    = 0;
    localparam int LANE_1    = 1;
    localparam int LANE_2    = 2;

    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } color_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] start_us;
        logic [TIME_W-1:0] stop_us;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
    } in_req_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            overridden;
        logic            accepted;
    } out_res_t;

    typedef struct packed {
        logic [TIME_W-1:0] start_us;
        logic [TIME_W-1:0] stop_us;
        color_t            color;
    } entry_t;

    // One compare lane: a - b, checked for sign, zero and a limit
    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [TIME_W:0]   lim;
    } lane_in_t;

    typedef struct packed {
        logic ge;      // a >= b
        logic gt;      // a > b
        logic in_lim;  // a - b < lim (valid when ge)
    } lane_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_FLUSH,
        ST_POST
    } state_t;

endpackage

`default_nettype wire

// File: hdl/tcot_cmp.sv
// ----------------------------------------------------------------------------
// tcot_cmp: shared time compare unit
// Three independent 64-bit subtract lanes; each reports a >= b, a > b and
// whether the difference stays under a limit. Used by add checks and scan.
// ----------------------------------------------------------------------------
`default_nettype none

module tcot_cmp (
    input  tcot_pkg::lane_in_t    [tcot_pkg::NUM_LANES-1:0] lanes_in,
    output tcot_pkg::lane_flags_t [tcot_pkg::NUM_LANES-1:0] lanes_out
);

    logic [tcot_pkg::TIME_W:0] diff [tcot_pkg::NUM_LANES];

    // Per-lane subtract and flag decode
    always_comb begin
        for (int i = 0; i < tcot_pkg::NUM_LANES; i++) begin
            diff[i] = {1'b0, lanes_in[i].a} - {1'b0, lanes_in[i].b};
            lanes_out[i].ge     = ~diff[i][tcot_pkg::TIME_W];
            lanes_out[i].gt     = ~diff[i][tcot_pkg::TIME_W] && (|diff[i]);
            lanes_out[i].in_lim = diff[i] < lanes_in[i].lim;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tcot_mem.sv
// ----------------------------------------------------------------------------
// tcot_mem: override entry storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcot_mem #(
    parameter int DEPTH  = tcot_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(tcot_pkg::TABLE_DEPTH_DEF)
) (
    input  wire                    aclk,
    input  wire                    wr_en,
    input  wire  [ADDR_W-1:0]      wr_addr,
    input  tcot_pkg::entry_t       wr_data,
    input  wire  [ADDR_W-1:0]      rd_addr,
    output tcot_pkg::entry_t       rd_data
);

    tcot_pkg::entry_t mem [DEPTH];
    tcot_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/timed_color_override_table_core.sv
// ----------------------------------------------------------------------------
// timed_color_override_table_core: ring table of timed RGB color overrides
//
// Requests arrive on the s_ channel (valid/ready), one result per request
// leaves on the m_ channel (valid/ready). cmd = add stores start, stop and
// color at the ring write position when the lead time and duration checks
// pass; cmd = query returns the local color when local_enable is set, else
// the color of the active entry with the greatest start, else the base color.
// The cfg_ port writes the local override registers, one per cycle.
// An add is checked and written in ST_ADD; a query scans the whole table,
// reading one entry per cycle from the table memory through the shared
// compare unit, then passes ST_FLUSH; both load the result register in
// ST_POST. One request is in work at a time.
// Reset clears the sequencer, write position, fill count and registers; the
// fill count marks never-written entries as empty, so no clearing pass.
// If the receiver stalls, the finished result holds on m_data and one more
// request may be accepted; its result waits until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_color_override_table_core #(
    parameter int TABLE_DEPTH = tcot_pkg::TABLE_DEPTH_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // configuration
    input  wire                                cfg_wr_en,
    input  wire  [tcot_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [tcot_pkg::CFG_W-1:0]         cfg_wr_data,
    // request channel
    input  wire                                s_valid,
    output logic                               s_ready,
    input  tcot_pkg::in_req_t                  s_data,
    // result channel
    output logic                               m_valid,
    input  wire                                m_ready,
    output tcot_pkg::out_res_t                 m_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    tcot_pkg::state_t  state_reg, state_next;
    tcot_pkg::in_req_t req_reg;

    logic [AW-1:0] idx_reg;
    logic [AW-1:0] wpos_reg;
    logic [CW-1:0] fill_reg;
    logic          live_reg;
    logic          add_ok_reg;
    logic          found_reg;
    logic [tcot_pkg::TIME_W-1:0] best_start_reg;
    tcot_pkg::color_t            best_color_reg;

    logic                 m_valid_reg;
    tcot_pkg::out_res_t   m_data_reg;

    logic                     local_enable_reg;
    logic [tcot_pkg::CH_W-1:0] local_red_reg;
    logic [tcot_pkg::CH_W-1:0] local_green_reg;
    logic [tcot_pkg::CH_W-1:0] local_blue_reg;

    // sequencer controls
    logic accept;
    logic add_run;
    logic scan_run;
    logic post_load;

    tcot_pkg::lane_in_t    [tcot_pkg::NUM_LANES-1:0] lanes_in;
    tcot_pkg::lane_flags_t [tcot_pkg::NUM_LANES-1:0] lanes_out;

    tcot_pkg::entry_t  rd_entry;
    tcot_pkg::entry_t  wr_entry;
    logic              wr_en;
    logic              add_ok;
    logic              hit;
    tcot_pkg::out_res_t res;

    // ------------------------------------------------------------------------
    // Entry memory and shared compare unit
    // ------------------------------------------------------------------------
    tcot_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wpos_reg),
        .wr_data (wr_entry),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    tcot_cmp u_cmp (
        .lanes_in  (lanes_in),
        .lanes_out (lanes_out)
    );

    // Lane operands: add checks or scan compares
    always_comb begin
        lanes_in = '0;
        if (state_reg == tcot_pkg::ST_ADD) begin
            lanes_in[tcot_pkg::LANE_0].a   = req_reg.start_us;
            lanes_in[tcot_pkg::LANE_0].b   = req_reg.now_us;
            lanes_in[tcot_pkg::LANE_0].lim = tcot_pkg::AHEAD_LIMIT_US;
            lanes_in[tcot_pkg::LANE_1].a   = req_reg.stop_us;
            lanes_in[tcot_pkg::LANE_1].b   = req_reg.start_us;
            lanes_in[tcot_pkg::LANE_1].lim = tcot_pkg::LENGTH_LIMIT_US;
        end else begin
            lanes_in[tcot_pkg::LANE_0].a = req_reg.now_us;
            lanes_in[tcot_pkg::LANE_0].b = rd_entry.start_us;
            lanes_in[tcot_pkg::LANE_1].a = rd_entry.stop_us;
            lanes_in[tcot_pkg::LANE_1].b = req_reg.now_us;
            lanes_in[tcot_pkg::LANE_2].a = rd_entry.start_us;
            lanes_in[tcot_pkg::LANE_2].b = best_start_reg;
        end
    end

    // Add passes: start not too far ahead, positive and bounded duration
    assign add_ok = (!lanes_out[tcot_pkg::LANE_0].gt || lanes_out[tcot_pkg::LANE_0].in_lim)
                    && lanes_out[tcot_pkg::LANE_1].gt && lanes_out[tcot_pkg::LANE_1].in_lim;

    // Scan hit: written entry, active now, later start than best so far
    assign hit = live_reg && lanes_out[tcot_pkg::LANE_0].ge
                 && lanes_out[tcot_pkg::LANE_1].ge && lanes_out[tcot_pkg::LANE_2].gt;

    assign wr_en = add_run && add_ok;

    always_comb begin
        wr_entry.start_us    = req_reg.start_us;
        wr_entry.stop_us     = req_reg.stop_us;
        wr_entry.color.red   = req_reg.red;
        wr_entry.color.green = req_reg.green;
        wr_entry.color.blue  = req_reg.blue;
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcot_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.cmd == tcot_pkg::CMD_ADD) ?
                                 tcot_pkg::ST_ADD : tcot_pkg::ST_SCAN;
                end
            end
            tcot_pkg::ST_ADD: begin
                state_next = tcot_pkg::ST_POST;
            end
            tcot_pkg::ST_SCAN: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = tcot_pkg::ST_FLUSH;
                end
            end
            tcot_pkg::ST_FLUSH: begin
                state_next = tcot_pkg::ST_POST;
            end
            tcot_pkg::ST_POST: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = tcot_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcot_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        add_run   = 1'b0;
        scan_run  = 1'b0;
        post_load = 1'b0;
        case (state_reg)
            tcot_pkg::ST_IDLE:  s_ready   = 1'b1;
            tcot_pkg::ST_ADD:   add_run   = 1'b1;
            tcot_pkg::ST_SCAN:  scan_run  = 1'b1;
            tcot_pkg::ST_FLUSH: scan_run  = 1'b0;
            tcot_pkg::ST_POST:  post_load = !m_valid_reg || m_ready;
            default:            s_ready   = 1'b0;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcot_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
    end

    // Scan index and read-data tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            live_reg <= 1'b0;
        end else begin
            live_reg <= scan_run && (CW'(idx_reg) < fill_reg);
            if (accept) begin
                idx_reg <= '0;
            end else if (scan_run) begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    // Best active entry so far
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg      <= 1'b0;
            best_start_reg <= '0;
        end else if (accept) begin
            found_reg      <= 1'b0;
            best_start_reg <= '0;
        end else if (hit) begin
            found_reg      <= 1'b1;
            best_start_reg <= rd_entry.start_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit) begin
            best_color_reg <= rd_entry.color;
        end
    end

    // Ring write position and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg   <= '0;
            fill_reg   <= '0;
            add_ok_reg <= 1'b0;
        end else begin
            if (add_run) begin
                add_ok_reg <= add_ok;
            end
            if (wr_en) begin
                wpos_reg <= (wpos_reg == LAST_IDX) ? '0 : wpos_reg + AW'(1);
                if (fill_reg != FULL_CNT) begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result selection and output register
    // ------------------------------------------------------------------------
    always_comb begin
        res = '0;
        if (req_reg.cmd == tcot_pkg::CMD_ADD) begin
            res.accepted = add_ok_reg;
        end else if (local_enable_reg) begin
            res.out_red    = local_red_reg;
            res.out_green  = local_green_reg;
            res.out_blue   = local_blue_reg;
            res.overridden = 1'b1;
        end else if (found_reg) begin
            res.out_red    = best_color_reg.red;
            res.out_green  = best_color_reg.green;
            res.out_blue   = best_color_reg.blue;
            res.overridden = 1'b1;
        end else begin
            res.out_red   = req_reg.red;
            res.out_green = req_reg.green;
            res.out_blue  = req_reg.blue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (post_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (post_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_enable_reg <= 1'b0;
            local_red_reg    <= '0;
            local_green_reg  <= '0;
            local_blue_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tcot_pkg::CFG_LOCAL_ENABLE: local_enable_reg <= cfg_wr_data[0];
                tcot_pkg::CFG_LOCAL_RED:    local_red_reg    <= cfg_wr_data;
                tcot_pkg::CFG_LOCAL_GREEN:  local_green_reg  <= cfg_wr_data;
                tcot_pkg::CFG_LOCAL_BLUE:   local_blue_reg   <= cfg_wr_data;
                default:                    local_enable_reg <= local_enable_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: bench/color_override_checker.sv
// ----------------------------------------------------------------------------
// color_override_checker: result predictor and scoreboard
// Watches the configuration port, the request and the result channel. Keeps a
// private copy of the override table and local color registers, predicts
// one result per accepted request, and compares every returned result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module color_override_checker
    import tcot_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_req_t              s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_res_t             m_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   adds_stored,
    output int                   adds_refused,
    output int                   local_hits,
    output int                   table_hits,
    output int                   base_hits
);

    // Private copy of the table and registers
    logic [TIME_W-1:0] slot_start [TABLE_DEPTH];
    logic [TIME_W-1:0] slot_stop  [TABLE_DEPTH];
    color_t            slot_color [TABLE_DEPTH];
    int                write_slot;
    logic              local_on;
    color_t            local_color;

    out_res_t awaited_results [$];
    int       result_number;

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        adds_stored  = 0;
        adds_refused = 0;
        local_hits   = 0;
        table_hits   = 0;
        base_hits    = 0;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
                     result_number, what, got, want);
    endtask

    // (later - earlier) / 1000 <= limit with truncation; a negative lead always passes
    function automatic bit lag_ok(logic [TIME_W-1:0] later, logic [TIME_W-1:0] earlier,
                                  int limit_ms);
        if (later <= earlier)
            return 1'b1;
        return ((later - earlier) / TIME_W'(US_PER_MS)) <= TIME_W'(limit_ms);
    endfunction

    // Predict the result of one request and update the table copy
    function automatic out_res_t resolve_request(in_req_t r);
        out_res_t          res;
        logic [TIME_W-1:0] best;
        bit                found;
        color_t            pick;
        res   = '0;
        best  = '0;
        found = 1'b0;
        pick  = '0;
        if (r.cmd == CMD_ADD) begin
            if (lag_ok(r.start_us, r.now_us, MAX_AHEAD_MS) && r.stop_us > r.start_us &&
                    lag_ok(r.stop_us, r.start_us, MAX_LENGTH_MS)) begin
                slot_start[write_slot] = r.start_us;
                slot_stop[write_slot]  = r.stop_us;
                slot_color[write_slot] = '{red: r.red, green: r.green, blue: r.blue};
                write_slot             = (write_slot + 1) % TABLE_DEPTH;
                res.accepted           = 1'b1;
                adds_stored++;
            end else begin
                adds_refused++;
            end
        end else if (local_on) begin
            res.out_red    = local_color.red;
            res.out_green  = local_color.green;
            res.out_blue   = local_color.blue;
            res.overridden = 1'b1;
            local_hits++;
        end else begin
            // strictly greater keeps the lowest index on equal starts; start zero never wins
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (r.now_us >= slot_start[i] && r.now_us <= slot_stop[i] &&
                        slot_start[i] > best) begin
                    best  = slot_start[i];
                    pick  = slot_color[i];
                    found = 1'b1;
                end
            end
            if (found) begin
                res.out_red    = pick.red;
                res.out_green  = pick.green;
                res.out_blue   = pick.blue;
                res.overridden = 1'b1;
                table_hits++;
            end else begin
                res.out_red   = r.red;
                res.out_green = r.green;
                res.out_blue  = r.blue;
                base_hits++;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        out_res_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_start[i] = '0;
                slot_stop[i]  = '0;
                slot_color[i] = '0;
            end
            write_slot    = 0;
            local_on      = 1'b0;
            local_color   = '0;
            result_number = 0;
            awaited_results.delete();
            outstanding <= 0;
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LOCAL_ENABLE: local_on          = cfg_wr_data[0];
                    CFG_LOCAL_RED:    local_color.red   = cfg_wr_data;
                    CFG_LOCAL_GREEN:  local_color.green = cfg_wr_data;
                    CFG_LOCAL_BLUE:   local_color.blue  = cfg_wr_data;
                    default: ;
                endcase
            end

            // returned result against the oldest prediction
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no request waiting", 64'(m_data), 64'd0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.out_red !== want.out_red)
                        report_mismatch("out_red", 64'(m_data.out_red), 64'(want.out_red));
                    if (m_data.out_green !== want.out_green)
                        report_mismatch("out_green", 64'(m_data.out_green),
                                        64'(want.out_green));
                    if (m_data.out_blue !== want.out_blue)
                        report_mismatch("out_blue", 64'(m_data.out_blue), 64'(want.out_blue));
                    if (m_data.overridden !== want.overridden)
                        report_mismatch("overridden", 64'(m_data.overridden),
                                        64'(want.overridden));
                    if (m_data.accepted !== want.accepted)
                        report_mismatch("accepted", 64'(m_data.accepted), 64'(want.accepted));
                end
                result_number++;
            end

            // accepted request
            if (s_valid && s_ready)
                awaited_results.push_back(resolve_request(s_data));

            outstanding <= awaited_results.size();
        end
    end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: timed color override table regression
// Drives add and query requests with random idling on both channels, walks
// the local override registers through several settings, and lets the
// checker predict and compare every result. A short directed part covers
// the limit checks, inclusive bounds, start-zero entries and equal starts;
// the random part builds overlapping overrides around a drifting clock.
// ----------------------------------------------------------------------------
module testbench;
    import tcot_pkg::*;

    localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
    localparam int PHASE_ITEMS  = 400;
    localparam int PHASE_COUNT  = 5;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam longint TIME_MAX_L = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_req_t              s_data      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    out_res_t             m_data;

    int mismatches, outstanding;
    int adds_stored, adds_refused, local_hits, table_hits, base_hits;

    int  cycle_count    = 0;
    int  stall_left     = 0;
    bit  steady         = 1'b0;
    int  settings_used  = 0;

    // scene clock and recent entry times for random requests
    logic [TIME_W-1:0] clock_base;
    logic [TIME_W-1:0] recent_start [8];
    logic [TIME_W-1:0] recent_stop  [8];
    int                recent_idx = 0;

    always #4 aclk = ~aclk;

    timed_color_override_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    color_override_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .adds_stored (adds_stored),
        .adds_refused(adds_refused),
        .local_hits  (local_hits),
        .table_hits  (table_hits),
        .base_hits   (base_hits)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                     outstanding);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stall bursts, none once steady
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Hold the request until it is taken
    task automatic send_request(in_req_t r);
        s_data  <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Optional idle burst between requests
    task automatic pace();
        if (!steady && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Stop sending until every predicted result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // Write all four local override registers, one per cycle
    task automatic set_local(logic [CFG_W-1:0] enable_word, color_t c);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_LOCAL_ENABLE;
        cfg_wr_data <= enable_word;
        @(posedge aclk);
        cfg_index   <= CFG_LOCAL_RED;
        cfg_wr_data <= c.red;
        @(posedge aclk);
        cfg_index   <= CFG_LOCAL_GREEN;
        cfg_wr_data <= c.green;
        @(posedge aclk);
        cfg_index   <= CFG_LOCAL_BLUE;
        cfg_wr_data <= c.blue;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic in_req_t mk(cmd_t cmd, logic [TIME_W-1:0] now,
                                   logic [TIME_W-1:0] start, logic [TIME_W-1:0] stop,
                                   logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                   logic [CH_W-1:0] b);
        in_req_t q;
        q.cmd      = cmd;
        q.now_us   = now;
        q.start_us = start;
        q.stop_us  = stop;
        q.red      = r;
        q.green    = g;
        q.blue     = b;
        return q;
    endfunction

    // Move a time by a signed offset, saturating at both ends of the range
    function automatic logic [TIME_W-1:0] shift_time(logic [TIME_W-1:0] t, longint off);
        longint tl;
        tl = longint'({1'b0, t});
        if (off < 0 && tl < -off)
            return '0;
        if (off > 0 && tl > TIME_MAX_L - off)
            return TIME_MAX;
        return TIME_W'(tl + off);
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        case ($urandom_range(0, 3))
            0:       return TIME_W'($urandom_range(0, 50_000_000));
            1:       return TIME_MAX - TIME_W'($urandom);
            default: return TIME_W'({$urandom, $urandom});
        endcase
    endfunction

    // Mostly well-formed adds and queries around the scene clock, some noise
    function automatic in_req_t next_request();
        in_req_t     r;
        int unsigned pick;
        int unsigned k;
        longint      lead;
        longint      span;
        pick    = $urandom_range(0, 99);
        k       = $urandom_range(0, 7);
        r.red   = CH_W'($urandom);
        r.green = CH_W'($urandom);
        r.blue  = CH_W'($urandom);
        if ($urandom_range(0, 199) == 0)
            clock_base = random_time();
        else
            clock_base = shift_time(clock_base, longint'($urandom_range(0, 400_000)));

        if (pick < 8) begin
            r.cmd      = cmd_t'($urandom_range(0, 1));
            r.now_us   = random_time();
            r.start_us = random_time();
            r.stop_us  = random_time();
        end else if (pick < 54) begin
            r.cmd    = CMD_ADD;
            r.now_us = shift_time(clock_base, longint'($urandom_range(0, 200_000)) - 100_000);
            case ($urandom_range(0, 9))
                0:       lead = 10_000_999;
                1:       lead = 10_001_000;
                2:       lead = -longint'($urandom_range(0, 30_000_000));
                3:       lead = longint'($urandom_range(10_001_000, 40_000_000));
                default: lead = longint'($urandom_range(0, 3_000_000)) - 1_000_000;
            endcase
            r.start_us = shift_time(r.now_us, lead);
            // equal starts exercise the lowest-index rule
            if ($urandom_range(0, 9) == 0)
                r.start_us = recent_start[k];
            case ($urandom_range(0, 11))
                0:       span = 10_000_999;
                1:       span = 10_001_000;
                2:       span = 0;
                3:       span = -longint'($urandom_range(1, 5_000_000));
                4:       span = longint'($urandom_range(1, 12_000_000));
                5:       span = 1;
                default: span = longint'($urandom_range(1, 3_000_000));
            endcase
            r.stop_us = shift_time(r.start_us, span);
            recent_start[recent_idx] = r.start_us;
            recent_stop[recent_idx]  = r.stop_us;
            recent_idx               = (recent_idx + 1) % 8;
        end else begin
            r.cmd      = CMD_QUERY;
            r.start_us = random_time();
            r.stop_us  = random_time();
            // hit the inclusive bounds of recent entries now and then
            case ($urandom_range(0, 9))
                0:       r.now_us = recent_start[k];
                1:       r.now_us = recent_stop[k];
                2:       r.now_us = shift_time(recent_stop[k], 1);
                3:       r.now_us = shift_time(recent_start[k], -1);
                default: r.now_us = shift_time(clock_base,
                                               longint'($urandom_range(0, 4_000_000)) - 1_000_000);
            endcase
        end
        return r;
    endfunction

    initial begin
        color_t phase_color;
        logic [CFG_W-1:0] phase_enable;

        for (int i = 0; i < 8; i++) begin
            recent_start[i] = '0;
            recent_stop[i]  = '0;
        end
        clock_base = TIME_W'(1_000_000);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: local override off, full-scale local color
        set_local(16'h0000, '{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF});

        // empty table passes the base color
        send_request(mk(CMD_QUERY, '0, '0, '0, 16'hFFFF, 16'h0000, 16'hFFFF)); pace();
        send_request(mk(CMD_QUERY, TIME_MAX, TIME_MAX, TIME_MAX, 16'h0000, 16'hFFFF, 16'h0000));
        pace();
        // entry with start zero is stored but never active
        send_request(mk(CMD_ADD, '0, '0, 63'd1000, 16'hAAAA, 16'h5555, 16'hAAAA)); pace();
        send_request(mk(CMD_QUERY, '0, '0, '0, 16'h1234, 16'h5678, 16'h9ABC)); pace();
        // lead time right at and just past the limit
        send_request(mk(CMD_ADD, 63'd1000, 63'd10001999, 63'd10002000,
                        16'h0101, 16'h0202, 16'h0303)); pace();
        send_request(mk(CMD_ADD, 63'd1000, 63'd10002000, 63'd10002001,
                        16'hDEAD, 16'hBEEF, 16'hCAFE)); pace();
        // zero and negative duration
        send_request(mk(CMD_ADD, 63'd5000, 63'd5000, 63'd5000, 16'h0BAD, 16'h0BAD, 16'h0BAD));
        pace();
        send_request(mk(CMD_ADD, 63'd5000, 63'd5000, 63'd4999, 16'h0BAD, 16'h0BAD, 16'h0BAD));
        pace();
        // duration right at and just past the limit
        send_request(mk(CMD_ADD, 63'd5000, 63'd5000, 63'd10005999,
                        16'h1111, 16'h2222, 16'h3333)); pace();
        send_request(mk(CMD_ADD, 63'd5000, 63'd5000, 63'd10006000,
                        16'h0BAD, 16'h0BAD, 16'h0BAD)); pace();
        // start far in the past
        send_request(mk(CMD_ADD, TIME_MAX, 63'd1, 63'd2, 16'h8001, 16'h8002, 16'h8003)); pace();
        // top of the time range
        send_request(mk(CMD_ADD, TIME_MAX - 1, TIME_MAX - 1, TIME_MAX,
                        16'hFFFF, 16'hFFFF, 16'hFFFF)); pace();
        send_request(mk(CMD_QUERY, TIME_MAX, '0, '0, 16'h0000, 16'h0000, 16'h0000)); pace();
        // equal start: the earlier slot wins
        send_request(mk(CMD_ADD, 63'd5000, 63'd5000, 63'd6000, 16'h4444, 16'h4444, 16'h4444));
        pace();
        send_request(mk(CMD_QUERY, 63'd5500, '0, '0, 16'h0000, 16'h0000, 16'h0000)); pace();
        // later start wins; stop bound is inclusive
        send_request(mk(CMD_ADD, 63'd5000, 63'd6000, 63'd7000, 16'h7777, 16'h7777, 16'h7777));
        pace();
        send_request(mk(CMD_QUERY, 63'd6000, '0, '0, 16'h0000, 16'h0000, 16'h0000)); pace();
        send_request(mk(CMD_QUERY, 63'd7000, '0, '0, 16'h0000, 16'h0000, 16'h0000)); pace();
        send_request(mk(CMD_QUERY, 63'd7001, '0, '0, 16'h0000, 16'h0000, 16'h0000)); pace();
        send_request(mk(CMD_QUERY, 63'd10002000, '0, '0, 16'h0000, 16'h0000, 16'h0000));
        pace();
        send_request(mk(CMD_ADD, TIME_MAX, TIME_MAX, TIME_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pace();
        send_request(mk(CMD_QUERY, 63'd1, '0, '0, 16'h0000, 16'h0000, 16'h0000)); pace();

        // Random part, one local override setting per phase
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain();
            case (phase)
                0: begin
                    phase_enable = 16'h0003;  // high bits of the write are dropped
                    phase_color  = '{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF};
                end
                1: begin
                    phase_enable = 16'hFFFE;
                    phase_color  = '{red: CH_W'($urandom), green: CH_W'($urandom),
                                     blue: CH_W'($urandom)};
                end
                2: begin
                    phase_enable = 16'h0001;
                    phase_color  = '0;
                end
                3: begin
                    phase_enable = 16'h0000;
                    phase_color  = '{red: 16'h5A5A, green: 16'hA5A5, blue: 16'h0F0F};
                end
                default: begin
                    phase_enable = 16'h0000;
                    phase_color  = '0;
                    steady <= 1'b1;           // last stretch runs without idling
                end
            endcase
            set_local(phase_enable, phase_color);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(next_request());
                if (!steady && $urandom_range(0, 149) == 0)
                    drain();
                else
                    pace();
            end
        end

        drain();
        repeat (TABLE_DEPTH + 8) @(posedge aclk);

        $display("Covered %0d adds (%0d stored, %0d refused) and %0d queries",
                 adds_stored + adds_refused, adds_stored, adds_refused,
                 local_hits + table_hits + base_hits);
        $display("Query colors: %0d local, %0d from table, %0d base; %0d register settings",
                 local_hits, table_hits, base_hits, settings_used);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
hdl/tcot_pkg.sv
hdl/tcot_cmp.sv
hdl/tcot_mem.sv
hdl/timed_color_override_table_core.sv
bench/color_override_checker.sv
bench/testbench.sv
